[rtl/top_k_score_selector_core_assert.svh]
// Assertion macros for the top-k score selector core.
// Included by the top level; no other dependencies.
`ifndef TOP_K_SCORE_SELECTOR_CORE_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the cycle after the antecedent.
`define TKSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkss assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define TKSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkss assertion failed");
`else
`define TKSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`define TKSS_ASSERT_SAME(label, clk, rst, ante, cons)
`endif
`endif

[rtl/tkss_pkg.sv]
// Shared types and constants for the top-k score selector core.
// No dependencies; used by tkss_cell and the top level.
package tkss_pkg;

   localparam int MAX_K_DEF       = 8;
   localparam int MAX_CLASSES_DEF = 1024;
   localparam int SCORE_W         = 16;
   localparam int CLASS_INDEX_W   = 10;
   localparam int K_W             = 4;
   localparam logic [K_W-1:0] K_RESET = 4'd5;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      vector_end;
   } req_type;

   typedef struct packed {
      logic [CLASS_INDEX_W-1:0]  class_index;
      logic signed [SCORE_W-1:0] class_score;
      logic                      final_rank;
   } rsp_type;

   // One kept or reported entry as it moves between neighboring cells.
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
   } slot_type;

endpackage

[rtl/top_k_score_selector_core.sv]
// Top-k score selector: a row of MAX_K cells keeps the best scores in order.
// One score per cycle if req_ready; each of the first MAX_CLASSES sorts in as it transfers.
// A vector_end transfer offers its first result the next cycle, then one per rsp_ready cycle.
// A vector_end waits until the previous report is empty or is sending its last result.
// Reset (synchronous, active high) empties all cells and sets k_ff to 5.
// Depends on tkss_pkg, tkss_cell and top_k_score_selector_core_assert.svh.
`include "top_k_score_selector_core_assert.svh"

module top_k_score_selector_core
   import tkss_pkg::*;
#(
   parameter int MAX_K       = MAX_K_DEF,
   parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data,
   input  logic           csr_wr_en,
   input  logic [K_W-1:0] csr_wr_data
);

   localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CNT_W = $clog2(MAX_CLASSES + 1);
   localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(MAX_CLASSES);

   logic [K_W-1:0]   k_ff, k_eff;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             req_xfer, rsp_xfer, saturated, ins_en, end_xfer;

   logic             beat_link  [0:MAX_K];
   slot_type         slot_link  [0:MAX_K];
   logic [IDX_W-1:0] index_link [0:MAX_K];
   slot_type         rep_link   [0:MAX_K];
   logic [IDX_W-1:0] rep_idx_link [0:MAX_K];
   logic [MAX_K-1:0] rep_keep, kept_valid_vec, rep_valid_vec;
   logic [CLASS_INDEX_W+IDX_W-1:0] index_wide;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign saturated = (pos_ff == POS_LIMIT);
   assign ins_en    = req_xfer && !saturated;
   assign end_xfer  = req_xfer && req_data.vector_end;

   // The report row may be reloaded in the cycle its last result leaves.
   assign req_ready = !rep_link[0].valid || !req_data.vector_end ||
                      (rsp_ready && !rep_link[1].valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
      end else if (csr_wr_en) begin
         k_ff <= csr_wr_data;
      end
   end

   assign k_eff = (k_ff == '0) ? K_W'(1) : k_ff;

   always_comb begin
      pos_in = pos_ff;
      if (end_xfer) begin
         pos_in = '0;
      end else if (ins_en) begin
         pos_in = pos_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign beat_link[0]         = 1'b0;
   assign slot_link[0]         = '0;
   assign index_link[0]        = '0;
   assign rep_link[MAX_K]      = '0;
   assign rep_idx_link[MAX_K]  = '0;

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      assign rep_keep[i] = (32'(k_eff) > 32'(i));

      tkss_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ins_en         (ins_en),
         .clear          (end_xfer),
         .new_score      (req_data.score),
         .new_index      (pos_ff[IDX_W-1:0]),
         .prev_beat      (beat_link[i]),
         .prev_slot      (slot_link[i]),
         .prev_index     (index_link[i]),
         .beat           (beat_link[i+1]),
         .slot           (slot_link[i+1]),
         .index          (index_link[i+1]),
         .rep_load       (end_xfer),
         .rep_keep       (rep_keep[i]),
         .rep_shift      (rsp_xfer),
         .rep_next_slot  (rep_link[i+1]),
         .rep_next_index (rep_idx_link[i+1]),
         .rep_slot       (rep_link[i]),
         .rep_index      (rep_idx_link[i])
      );

      assign kept_valid_vec[i] = slot_link[i+1].valid;
      assign rep_valid_vec[i]  = rep_link[i].valid;
   end

   assign index_wide           = {{CLASS_INDEX_W{1'b0}}, rep_idx_link[0]};
   assign rsp_valid            = rep_link[0].valid;
   assign rsp_data.class_index = index_wide[CLASS_INDEX_W-1:0];
   assign rsp_data.class_score = rep_link[0].score;
   assign rsp_data.final_rank  = !rep_link[1].valid;

   // A vector_end transfer always leaves at least one result to report.
   `TKSS_ASSERT_NEXT(a_end_gives_result, clock, reset, end_xfer, rsp_valid)
   // Without a result at rank zero the whole report row is empty.
   `TKSS_ASSERT_SAME(a_report_from_head, clock, reset, !rsp_valid, rep_valid_vec == '0)
   // After a score is sorted in mid-vector, the best rank is always occupied.
   `TKSS_ASSERT_NEXT(a_insert_fills_head, clock, reset,
                     ins_en && !req_data.vector_end, kept_valid_vec[0])

endmodule

[rtl/tkss_cell.sv]
// One rank of the selector: a kept entry for insertion sort and a report slot.
// Depends on tkss_pkg.
module tkss_cell
   import tkss_pkg::*;
#(
   parameter int IDX_W = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      ins_en,
   input  logic                      clear,
   input  logic signed [SCORE_W-1:0] new_score,
   input  logic [IDX_W-1:0]          new_index,
   input  logic                      prev_beat,
   input  slot_type                  prev_slot,
   input  logic [IDX_W-1:0]          prev_index,
   output logic                      beat,
   output slot_type                  slot,
   output logic [IDX_W-1:0]          index,
   input  logic                      rep_load,
   input  logic                      rep_keep,
   input  logic                      rep_shift,
   input  slot_type                  rep_next_slot,
   input  logic [IDX_W-1:0]          rep_next_index,
   output slot_type                  rep_slot,
   output logic [IDX_W-1:0]          rep_index
);

   slot_type         slot_ff, slot_in, ins_slot;
   logic [IDX_W-1:0] index_ff, index_in, ins_index;
   slot_type         rep_ff, rep_in;
   logic [IDX_W-1:0] rep_index_ff, rep_index_in;

   // An equal kept score has the lower index, so only a strictly larger score beats it.
   assign beat = ins_en && (!slot_ff.valid || (slot_ff.score < new_score));

   always_comb begin
      ins_slot  = slot_ff;
      ins_index = index_ff;
      if (beat) begin
         if (prev_beat) begin
            ins_slot  = prev_slot;
            ins_index = prev_index;
         end else begin
            ins_slot.valid = 1'b1;
            ins_slot.score = new_score;
            ins_index      = new_index;
         end
      end
      slot_in  = ins_slot;
      index_in = ins_index;
      if (clear) begin
         slot_in.valid = 1'b0;
      end
   end

   // The report row takes the post-insertion contents, then shifts toward rank zero.
   always_comb begin
      rep_in       = rep_ff;
      rep_index_in = rep_index_ff;
      if (rep_load) begin
         rep_in.valid = ins_slot.valid && rep_keep;
         rep_in.score = ins_slot.score;
         rep_index_in = ins_index;
      end else if (rep_shift) begin
         rep_in       = rep_next_slot;
         rep_index_in = rep_next_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         rep_ff.valid  <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
         rep_ff.valid  <= rep_in.valid;
      end
      slot_ff.score <= slot_in.score;
      index_ff      <= index_in;
      rep_ff.score  <= rep_in.score;
      rep_index_ff  <= rep_index_in;
   end

   assign slot      = slot_ff;
   assign index     = index_ff;
   assign rep_slot  = rep_ff;
   assign rep_index = rep_index_ff;

endmodule
